// ===== src/spk128_pkg.sv =====
// shared types, constants and round helpers for the speck128/128 encrypt unit
// no dependencies

package spk128_pkg;

  localparam int unsigned WordW         = 64;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned RoundCountDef = 32;
  localparam int unsigned RotX          = 8;
  localparam int unsigned RotY          = 3;

  localparam logic [WordW-1:0] KeyLowRst  = 64'h0807060504030201;
  localparam logic [WordW-1:0] KeyHighRst = 64'h0403020501010203;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow  = 2'd0,
    CfgKeyHigh = 2'd1
  } cfg_idx_e;

  // cipher pair and key schedule pair carried along the chain
  typedef struct packed {
    word_t x;
    word_t y;
    word_t k;
    word_t l;
  } state_t;

  function automatic word_t ror_x(input word_t v);
    return (v >> RotX) | (v << (WordW - RotX));
  endfunction

  function automatic word_t rol_y(input word_t v);
    return (v << RotY) | (v >> (WordW - RotY));
  endfunction

endpackage

// ===== src/spk128_round_cell.sv =====
// one speck round cell: round function on data and key schedule, one register stage
// depends on spk128_pkg

module spk128_round_cell #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  spk128_pkg::state_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output spk128_pkg::state_t data_o
);
  import spk128_pkg::*;

  localparam word_t RoundConst = WordW'(ROUND_IDX);

  logic   valid_q;
  state_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.x = (ror_x(data_i.x) + data_i.y) ^ data_i.k;
    data_d.y = rol_y(data_i.y) ^ data_d.x;
    data_d.l = (ror_x(data_i.l) + data_i.k) ^ RoundConst;
    data_d.k = rol_y(data_i.k) ^ data_d.l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/speck128_128_encrypt_unit.sv =====
// top level of the speck128/128 encrypt unit: key registers and the chain of round cells
// depends on spk128_pkg and spk128_round_cell

// Fully unrolled Speck128/128 encryption. Each round is one cell with its own register.
// A word accepted at the input passes through every cell register in turn before its
// ciphertext appears. A new word can be taken every cycle while the output is not
// stalled. Each cell holds one add-rotate-xor round for the data and one for the
// on-the-fly key schedule; ready ripples back through the cells, so a stalled output
// only blocks input once every cell is occupied. The user must write the key through the
// configuration port only while no word is in flight; the block does not enforce this.

module speck128_128_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = spk128_pkg::RoundCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spk128_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [spk128_pkg::WordW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spk128_pkg::WordW-1:0]   plain_high_i,
  input  logic [spk128_pkg::WordW-1:0]   plain_low_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spk128_pkg::WordW-1:0]   cipher_high_o,
  output logic [spk128_pkg::WordW-1:0]   cipher_low_o
);
  import spk128_pkg::*;

  word_t  key_low_q, key_high_q;
  logic   [ROUND_COUNT:0] vld;
  logic   [ROUND_COUNT:0] rdy;
  state_t stage [ROUND_COUNT+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= KeyLowRst;
      key_high_q <= KeyHighRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        CfgKeyHigh: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld[0]     = in_valid_i;
  assign in_ready_o = rdy[0];
  assign stage[0]   = '{x: plain_high_i, y: plain_low_i, k: key_low_q, l: key_high_q};

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    spk128_round_cell #(
      .ROUND_IDX(r)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[r]),
      .ready_o(rdy[r]),
      .data_i (stage[r]),
      .valid_o(vld[r+1]),
      .ready_i(rdy[r+1]),
      .data_o (stage[r+1])
    );
  end

  assign rdy[ROUND_COUNT] = out_ready_i;
  assign out_valid_o      = vld[ROUND_COUNT];
  assign cipher_high_o    = stage[ROUND_COUNT].x;
  assign cipher_low_o     = stage[ROUND_COUNT].y;

`ifndef ASSERT_OFF
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld[ROUND_COUNT:1]) && !out_ready_i))
    else $error("input blocked while the chain has a free cell");

  a_key_low_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == CfgKeyLow)) |=> (key_low_q == $past(cfg_data_i)))
    else $error("low key word not written");

  a_key_high_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == CfgKeyHigh)) |=> (key_high_q == $past(cfg_data_i)))
    else $error("high key word not written");
`endif

endmodule

// ===== sim/speck_cipher_checker.sv =====
// checker for the speck128/128 encrypt unit: watches the key, plaintext and ciphertext channels
// keeps its own key copy, predicts each ciphertext word and compares them in order
// depends on spk128_pkg

module speck_cipher_checker #(
  parameter int unsigned RoundCount = spk128_pkg::RoundCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [spk128_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [spk128_pkg::WordW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [spk128_pkg::WordW-1:0]   plain_high_i,
  input  logic [spk128_pkg::WordW-1:0]   plain_low_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [spk128_pkg::WordW-1:0]   cipher_high_i,
  input  logic [spk128_pkg::WordW-1:0]   cipher_low_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    words_due_o
);

  import spk128_pkg::*;

  localparam int unsigned XShift = 8;
  localparam int unsigned YShift = 3;

  typedef struct packed {
    word_t high;
    word_t low;
  } cipher_t;

  word_t       key_low;
  word_t       key_high;
  cipher_t     cipher_due_q[$];
  int unsigned mismatch_count = 0;

  assign mismatch_count_o = mismatch_count;

  function automatic cipher_t encrypt_block(input word_t px, input word_t py,
                                            input word_t k0, input word_t l0);
    word_t   x;
    word_t   y;
    word_t   k;
    word_t   l;
    cipher_t c;
    x = px;
    y = py;
    k = k0;
    l = l0;
    for (int unsigned r = 0; r < RoundCount; r++) begin
      x = ({x[XShift-1:0], x[WordW-1:XShift]} + y) ^ k;
      y = {y[WordW-YShift-1:0], y[WordW-1:WordW-YShift]} ^ x;
      l = ({l[XShift-1:0], l[WordW-1:XShift]} + k) ^ word_t'(r);
      k = {k[WordW-YShift-1:0], k[WordW-1:WordW-YShift]} ^ l;
    end
    c.high = x;
    c.low  = y;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_t want;
    if (!rst_ni) begin
      key_low  = KeyLowRst;
      key_high = KeyHighRst;
      cipher_due_q.delete();
      words_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cipher_due_q.size() == 0) begin
          report_mismatch("cipher word with none due, high", cipher_high_i, '0);
        end else begin
          want = cipher_due_q.pop_front();
          if (cipher_high_i !== want.high) begin
            report_mismatch("cipher_high", cipher_high_i, want.high);
          end
          if (cipher_low_i !== want.low) begin
            report_mismatch("cipher_low", cipher_low_i, want.low);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        cipher_due_q.push_back(encrypt_block(plain_high_i, plain_low_i, key_low, key_high));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgKeyLow) begin
          key_low = cfg_data_i;
        end else if (cfg_index_i == CfgKeyHigh) begin
          key_high = cfg_data_i;
        end
      end
      words_due_o <= cipher_due_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// top of the speck128/128 encrypt unit testbench: clock, reset, key writes and plaintext stimulus
// depends on spk128_pkg, speck128_128_encrypt_unit and speck_cipher_checker

module testbench;

  import spk128_pkg::*;

  localparam int unsigned RoundCount = RoundCountDef;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseWords = 125;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = CfgKeyLow;
  word_t              cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  word_t              plain_high_i = '0;
  word_t              plain_low_i  = '0;
  logic               out_ready_i  = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  word_t              cipher_high_o;
  word_t              cipher_low_o;

  int unsigned send_idle_pct  = 8;
  int unsigned recv_idle_pct  = 66;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count;
  int unsigned words_due;

  speck128_128_encrypt_unit #(
    .ROUND_COUNT(RoundCount)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .plain_high_i (plain_high_i),
    .plain_low_i  (plain_low_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cipher_high_o(cipher_high_o),
    .cipher_low_o (cipher_low_o)
  );

  speck_cipher_checker #(
    .RoundCount(RoundCount)
  ) u_cipher_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .plain_high_i    (plain_high_i),
    .plain_low_i     (plain_low_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cipher_high_i   (cipher_high_o),
    .cipher_low_i    (cipher_low_o),
    .mismatch_count_o(mismatch_count),
    .words_due_o     (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("speck128_128_encrypt_unit verification failed");
      $finish;
    end
  end

  function automatic word_t rand_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(11))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(WordW - 1);
      3: w = ~(word_t'(1) << $urandom_range(WordW - 1));
      default: ;
    endcase
    return w;
  endfunction

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input word_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input word_t hi, input word_t lo);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    plain_high_i <= hi;
    plain_low_i  <= lo;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (RoundCount + 4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    write_key(CfgKeyLow, rand_word());
    write_key(CfgKeyHigh, rand_word());
    if ($urandom_range(1)) begin
      write_key($urandom_range(1) ? CfgSpareA : CfgSpareB, rand_word());
    end
    for (int unsigned n = 0; n < PhaseWords; n++) begin
      send_word(rand_word(), rand_word());
    end
    drain_words();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key
    send_word('0, '0);
    send_word('1, '1);
    send_word('0, '1);
    send_word('1, '0);
    send_word({32{2'b10}}, {32{2'b01}});
    send_word(64'h1, 64'h8000_0000_0000_0000);
    send_word(64'h8000_0000_0000_0000, 64'h1);
    send_word(64'h6c61_7669_7571_6520, 64'h7469_2065_6461_6d20);
    drain_words();

    // published key, then writes to unused indexes that must be ignored
    write_key(CfgKeyLow, 64'h0706_0504_0302_0100);
    write_key(CfgKeyHigh, 64'h0f0e_0d0c_0b0a_0908);
    write_key(CfgSpareA, '1);
    write_key(CfgSpareB, '0);
    send_word(64'h6c61_7669_7571_6520, 64'h7469_2065_6461_6d20);
    send_word('0, '0);
    send_word('1, '1);
    drain_words();

    write_key(CfgKeyLow, '1);
    write_key(CfgKeyHigh, '1);
    send_word('0, '0);
    send_word('1, '1);
    send_word({32{2'b01}}, {32{2'b10}});
    drain_words();

    write_key(CfgKeyLow, '0);
    write_key(CfgKeyHigh, '0);
    send_word('0, '0);
    send_word('1, '0);
    send_word('0, '1);
    drain_words();

    random_phase(8, 66);
    random_phase(8, 66);
    random_phase(66, 8);
    random_phase(66, 8);
    random_phase(0, 0);
    random_phase(0, 0);

    if (mismatch_count == 0 && words_due == 0) begin
      $display("speck128_128_encrypt_unit verification clean");
    end else begin
      $display("speck128_128_encrypt_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/spk128_pkg.sv
src/spk128_round_cell.sv
src/speck128_128_encrypt_unit.sv
sim/speck_cipher_checker.sv
sim/testbench.sv
